/* rtl/ccm_pkg.sv */
// Shared types, constants and AES helper functions for the CCM seal/open block.
// Used by ccm_front, ccm_aes, ccm_core and aes_ccm_seal_open. No dependencies.
package ccm_pkg;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic [15:0] aad_length;
    logic [15:0] payload_length;
    logic        open_message;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [1:0] status;
    logic       last;
  } out_t;

  typedef struct packed {
    logic         start;
    logic         k256;
    logic [255:0] key;
    logic [127:0] blk;
  } aes_req_t;

  typedef struct packed {
    logic         busy;
    logic         done;
    logic [127:0] blk;
  } aes_rsp_t;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_AAD   = 2'd1;
  localparam logic [1:0] CMD_PAY   = 2'd2;
  localparam logic [1:0] CMD_TAG   = 2'd3;

  localparam logic [1:0] KIND_PAY  = 2'd0;
  localparam logic [1:0] KIND_TAG  = 2'd1;
  localparam logic [1:0] KIND_STAT = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISM  = 2'd1;
  localparam logic [1:0] ST_BADN  = 2'd2;
  localparam logic [1:0] ST_OOS   = 2'd3;

  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_NHEAD = 3'd4;
  localparam logic [2:0] REG_NTAIL = 3'd5;
  localparam logic [2:0] REG_NLEN  = 3'd6;
  localparam logic [2:0] REG_K256  = 3'd7;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte 0 sits in the top bits of the block.
  function automatic logic [7:0] get_byte(input logic [127:0] v, input logic [3:0] i);
    logic [127:0] sh;
    sh = v << {i, 3'b000};
    return sh[127:120];
  endfunction

  function automatic logic [127:0] set_byte(input logic [127:0] v, input logic [3:0] i,
                                            input logic [7:0] b);
    logic [6:0] sh;
    sh = {4'd15 - i, 3'b000};
    return (v & ~(128'hff << sh)) | ({120'b0, b} << sh);
  endfunction

  // Next four round key words from the previous four and the newest word.
  function automatic logic [127:0] key_step(input logic [127:0] prev, input logic [31:0] lw,
                                            input logic rot, input logic [7:0] rcon);
    logic [31:0] t, w0, w1, w2, w3;
    t  = rot ? (sub_word({lw[23:0], lw[31:24]}) ^ {rcon, 24'b0}) : sub_word(lw);
    w0 = prev[127:96] ^ t;
    w1 = prev[95:64] ^ w0;
    w2 = prev[63:32] ^ w1;
    w3 = prev[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic fin);
    logic [7:0]   sb [16];
    logic [7:0]   t  [16];
    logic [7:0]   m  [16];
    logic [7:0]   a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) sb[i] = SBOX[s[127-8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++) t[j+4*c] = sb[j+4*((c+j)%4)];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
      m[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
      m[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
      m[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = (fin ? t[i] : m[i]) ^ rk[127-8*i -: 8];
    return r;
  endfunction

  // flags, nonce bytes 0..n-1, then the counter value in the low bytes
  function automatic logic [127:0] form_block(input logic [119:0] nonce, input logic [3:0] n,
                                              input logic [7:0] flags, input logic [15:0] val);
    logic [127:0] b;
    b = '0;
    b[127:120] = flags;
    for (int i = 1; i < 16; i++) begin
      if (4'(i) <= n) b[127-8*i -: 8] = nonce[119-8*(i-1) -: 8];
      else if (i == 14) b[127-8*i -: 8] = val[15:8];
      else if (i == 15) b[127-8*i -: 8] = val[7:0];
    end
    return b;
  endfunction

endpackage

/* rtl/aes_ccm_seal_open.sv */
// Top level of the AES-CCM seal/open block: front queue, back sequencer, AES round unit.
// Depends on ccm_pkg, ccm_front, ccm_aes and ccm_core.
//
//   channel  ports                         accepted when
//   input    in_valid  in_ready  in_data   in_valid & in_ready
//   result   out_valid out_ready out_data  out_valid & out_ready
//   config   cfg_we cfg_index cfg_data     cfg_we (ignored in the AAD, payload and tag-check phases)
//
// Every 16-byte payload block adds one pass of the round unit for CTR, and every 16-byte block
// adds one pass followed by the end step (S_END) for CBC-MAC.
// A start takes one pass of the round unit (B0), the tag one pass (A0) followed by its bytes.
// Reset is synchronous; no clearing pass is needed after it.
// The four-entry input queue keeps accepting, until it is full, while results stall at the output register.
module aes_ccm_seal_open #(
  parameter int TAG_BYTES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ccm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ccm_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data
);
  import ccm_pkg::*;

  logic     hd_valid, pop;
  in_t      hd;
  aes_req_t aes_req;
  aes_rsp_t aes_rsp;

  ccm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .hd_valid (hd_valid),
    .hd       (hd),
    .pop      (pop)
  );

  ccm_aes u_aes (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (aes_req),
    .rsp   (aes_rsp)
  );

  ccm_core #(.TAG_BYTES(TAG_BYTES)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .hd_valid  (hd_valid),
    .hd        (hd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .aes_req   (aes_req),
    .aes_rsp   (aes_rsp)
  );

endmodule

/* rtl/ccm_front.sv */
// Front end: accepts input items into a four-entry queue toward the back end.
// Depends on ccm_pkg.
module ccm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ccm_pkg::in_t  in_data,
  output logic          hd_valid,
  output ccm_pkg::in_t  hd,
  input  logic          pop
);
  import ccm_pkg::*;

  in_t        q_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 3'd4);
  assign hd_valid = (cnt_r != 3'd0);
  assign hd       = q_r[rp_r];
  assign push     = in_valid && in_ready;

  always_comb begin
    wp_nxt  = push ? wp_r + 2'd1 : wp_r;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + {2'b0, push} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_data;
  end

endmodule

/* rtl/ccm_aes.sv */
// Iterative AES-128/256 encryption, one round per cycle, round keys expanded on the fly.
// Depends on ccm_pkg.
module ccm_aes (
  input  logic              clk,
  input  logic              rst_n,
  input  ccm_pkg::aes_req_t req,
  output ccm_pkg::aes_rsp_t rsp
);
  import ccm_pkg::*;

  logic         busy_r, busy_nxt, done_r, done_nxt, k256_r, k256_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic [127:0] s_r, s_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [127:0] rk, nk;
  logic         fin;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k256_nxt = k256_r;
    rnd_nxt  = rnd_r;
    rcon_nxt = rcon_r;
    s_nxt    = s_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    fin      = (rnd_r == (k256_r ? 4'd14 : 4'd10));
    nk       = key_step(a_r, k256_r ? b_r[31:0] : a_r[31:0], ~k256_r | rnd_r[0], rcon_r);
    rk       = k256_r ? b_r : nk;
    if (req.start) begin
      busy_nxt = 1'b1;
      k256_nxt = req.k256;
      rnd_nxt  = 4'd1;
      rcon_nxt = 8'h01;
      s_nxt    = req.blk ^ req.key[255:128];
      a_nxt    = req.key[255:128];
      b_nxt    = req.key[127:0];
    end else if (busy_r) begin
      s_nxt   = aes_round(s_r, rk, fin);
      rnd_nxt = rnd_r + 4'd1;
      if (k256_r) begin
        a_nxt = b_r;
        b_nxt = nk;
        if (rnd_r[0]) rcon_nxt = xtime(rcon_r);
      end else begin
        a_nxt    = nk;
        rcon_nxt = xtime(rcon_r);
      end
      if (fin) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k256_r <= k256_nxt;
    rnd_r  <= rnd_nxt;
    rcon_r <= rcon_nxt;
    s_r    <= s_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.blk  = s_r;

endmodule

/* rtl/ccm_core.sv */
// Back end: CCM sequencer with CBC-MAC, CTR keystream, tag, configuration and output register.
// Depends on ccm_pkg; drives one ccm_aes through aes_req_t / aes_rsp_t.
module ccm_core #(
  parameter int TAG_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              hd_valid,
  input  ccm_pkg::in_t      hd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ccm_pkg::out_t     out_data,
  output ccm_pkg::aes_req_t aes_req,
  input  ccm_pkg::aes_rsp_t aes_rsp
);
  import ccm_pkg::*;

  localparam logic [2:0] TAG_FLAG = 3'((TAG_BYTES - 2) / 2);
  localparam logic [4:0] TAG_LAST = 5'(TAG_BYTES - 1);
  localparam logic [4:0] TAG_CNT  = 5'(TAG_BYTES);

  localparam logic [2:0] S_FETCH  = 3'd0;
  localparam logic [2:0] S_EMITP  = 3'd1;
  localparam logic [2:0] S_AESW   = 3'd2;
  localparam logic [2:0] S_END    = 3'd3;
  localparam logic [2:0] S_TAGOUT = 3'd4;
  localparam logic [2:0] S_STAT   = 3'd5;

  localparam logic [1:0] C_B0  = 2'd0;
  localparam logic [1:0] C_KS  = 2'd1;
  localparam logic [1:0] C_MAC = 2'd2;
  localparam logic [1:0] C_A0  = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_AAD  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;
  localparam logic [1:0] PH_TAG  = 2'd3;

  logic [255:0] key_r;
  logic [63:0]  nh_r;
  logic [39:0]  nt_r;
  logic [3:0]   nlen_r;
  logic         k256_r;

  logic [2:0]   state_r, state_nxt;
  logic [1:0]   cont_r, cont_nxt, phase_r, phase_nxt, stat_r, stat_nxt;
  logic         dir_r, dir_nxt, mism_r, mism_nxt, slast_r, slast_nxt;
  logic [4:0]   pos_r, pos_nxt, cnt_r, cnt_nxt;
  logic [15:0]  ctr_r, ctr_nxt, blen_r, blen_nxt, alen_r, alen_nxt;
  logic [127:0] mac_r, mac_nxt, ks_r, ks_nxt, gath_r, gath_nxt;
  logic [7:0]   d_r, d_nxt;
  logic         out_valid_r, out_valid_nxt;
  out_t         out_r, out_nxt;

  logic         out_free, emit, adv, fin, mism_n, bad_n;
  logic [4:0]   pn;
  logic [15:0]  ln;
  logic [127:0] gn, nres;
  logic [119:0] nonce;
  logic [2:0]   lm1;
  logic [7:0]   ksb, o;

  assign out_free = !out_valid_r || out_ready;
  assign nonce    = {nh_r, nt_r, 16'b0};
  assign lm1      = 3'(4'd14 - nlen_r);
  assign ksb      = get_byte(ks_r, pos_r[3:0]);
  assign bad_n    = (nlen_r < 4'd7) || (nlen_r > 4'd13);

  always_comb begin
    state_nxt = state_r;  cont_nxt = cont_r;  phase_nxt = phase_r;
    stat_nxt  = stat_r;   slast_nxt = slast_r; dir_nxt = dir_r;
    mism_nxt  = mism_r;   pos_nxt = pos_r;    cnt_nxt = cnt_r;
    ctr_nxt   = ctr_r;    blen_nxt = blen_r;  alen_nxt = alen_r;
    mac_nxt   = mac_r;    ks_nxt = ks_r;      gath_nxt = gath_r;
    d_nxt     = d_r;
    pop = 1'b0; emit = 1'b0; adv = 1'b0; fin = 1'b0;
    out_nxt = '0;
    pn = pos_r + 5'd1;
    ln = 16'd0;
    gn = gath_r;
    o  = d_r ^ ksb;
    mism_n = 1'b0;
    nres = mac_r ^ aes_rsp.blk;
    aes_req.start = 1'b0;
    aes_req.k256  = k256_r;
    aes_req.key   = key_r;
    aes_req.blk   = mac_r ^ gath_r;

    unique case (state_r)
      S_FETCH: begin
        if (hd_valid) begin
          pop = 1'b1;
          priority if (hd.cmd == CMD_START) begin
            if (bad_n) begin
              phase_nxt = PH_IDLE;
              stat_nxt  = ST_BADN;
              slast_nxt = 1'b1;
              state_nxt = S_STAT;
            end else begin
              dir_nxt  = hd.open_message;
              alen_nxt = hd.aad_length;
              blen_nxt = hd.payload_length;
              ctr_nxt  = '0;
              mism_nxt = 1'b0;
              mac_nxt  = '0;
              ks_nxt   = '0;
              gath_nxt = '0;
              pos_nxt  = '0;
              aes_req.start = 1'b1;
              aes_req.blk   = form_block(nonce, nlen_r,
                {1'b0, hd.aad_length != 16'd0, TAG_FLAG, lm1}, hd.payload_length);
              cont_nxt  = C_B0;
              state_nxt = S_AESW;
            end
          end else if (hd.cmd == CMD_AAD && phase_r == PH_AAD) begin
            ln  = alen_r - 16'd1;
            gn  = set_byte(gath_r, pos_r[3:0], hd.data_byte);
            gath_nxt = gn;
            pos_nxt  = pn;
            alen_nxt = ln;
            adv = 1'b1;
          end else if (hd.cmd == CMD_PAY && phase_r == PH_PAY) begin
            d_nxt = hd.data_byte;
            if (pos_r == 5'd0) begin
              ctr_nxt = ctr_r + 16'd1;
              aes_req.start = 1'b1;
              aes_req.blk   = form_block(nonce, nlen_r, {5'b0, lm1}, ctr_r + 16'd1);
              cont_nxt  = C_KS;
              state_nxt = S_AESW;
            end else begin
              state_nxt = S_EMITP;
            end
          end else if (hd.cmd == CMD_TAG && phase_r == PH_TAG) begin
            mism_n = mism_r | (hd.data_byte != ksb);
            if (pn >= TAG_CNT || pn >= 5'd16) begin
              phase_nxt = PH_IDLE;
              stat_nxt  = mism_n ? ST_MISM : ST_OK;
              slast_nxt = 1'b1;
              state_nxt = S_STAT;
            end else begin
              pos_nxt  = pn;
              mism_nxt = mism_n;
            end
          end else begin
            stat_nxt  = ST_OOS;
            slast_nxt = 1'b0;
            state_nxt = S_STAT;
          end
        end
      end
      S_EMITP: begin
        if (out_free) begin
          emit = 1'b1;
          out_nxt = '{out_byte: o, kind: KIND_PAY, status: ST_OK, last: 1'b0};
          ln  = blen_r - 16'd1;
          gn  = set_byte(gath_r, pos_r[3:0], dir_r ? o : d_r);
          gath_nxt = gn;
          pos_nxt  = pn;
          blen_nxt = ln;
          adv = 1'b1;
        end
      end
      S_AESW: begin
        if (aes_rsp.done) begin
          unique case (cont_r)
            C_B0: begin
              mac_nxt = aes_rsp.blk;
              if (alen_r != 16'd0) begin
                phase_nxt = PH_AAD;
                state_nxt = S_FETCH;
                if (alen_r < 16'hff00) begin
                  gath_nxt = {alen_r, 112'b0};
                  pos_nxt  = 5'd2;
                end else begin
                  gath_nxt = {16'hfffe, 16'h0000, alen_r, 80'b0};
                  pos_nxt  = 5'd6;
                end
              end else if (blen_r != 16'd0) begin
                phase_nxt = PH_PAY;
                state_nxt = S_FETCH;
              end else begin
                fin = 1'b1;
              end
            end
            C_KS: begin
              ks_nxt    = aes_rsp.blk;
              state_nxt = S_EMITP;
            end
            C_MAC: begin
              mac_nxt   = aes_rsp.blk;
              gath_nxt  = '0;
              pos_nxt   = '0;
              state_nxt = S_END;
            end
            C_A0: begin
              ks_nxt  = nres;
              cnt_nxt = '0;
              if (!dir_r) begin
                phase_nxt = PH_IDLE;
                state_nxt = S_TAGOUT;
              end else begin
                pos_nxt   = '0;
                mism_nxt  = 1'b0;
                phase_nxt = PH_TAG;
                state_nxt = S_FETCH;
              end
            end
            default: state_nxt = S_FETCH;
          endcase
        end
      end
      S_END: begin
        state_nxt = S_FETCH;
        if (phase_r == PH_AAD && alen_r == 16'd0) begin
          if (blen_r != 16'd0) phase_nxt = PH_PAY;
          else fin = 1'b1;
        end else if (phase_r == PH_PAY && blen_r == 16'd0) begin
          fin = 1'b1;
        end
      end
      S_TAGOUT: begin
        if (out_free) begin
          emit = 1'b1;
          out_nxt = '{out_byte: get_byte(ks_r, cnt_r[3:0]), kind: KIND_TAG, status: ST_OK,
                      last: cnt_r == TAG_LAST};
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == TAG_LAST) state_nxt = S_FETCH;
        end
      end
      S_STAT: begin
        if (out_free) begin
          emit = 1'b1;
          out_nxt = '{out_byte: 8'h00, kind: KIND_STAT, status: stat_r, last: slast_r};
          state_nxt = S_FETCH;
        end
      end
      default: state_nxt = S_FETCH;
    endcase

    // after a data byte: fold a full or final block into the MAC
    if (adv) begin
      if (pn == 5'd16 || (ln == 16'd0 && pn != 5'd0)) begin
        aes_req.start = 1'b1;
        aes_req.blk   = mac_r ^ gn;
        cont_nxt  = C_MAC;
        state_nxt = S_AESW;
      end else if (ln == 16'd0) begin
        state_nxt = S_END;
      end else begin
        state_nxt = S_FETCH;
      end
    end

    // MAC complete: encrypt A0 for the tag
    if (fin) begin
      aes_req.start = 1'b1;
      aes_req.blk   = form_block(nonce, nlen_r, {5'b0, lm1}, 16'd0);
      cont_nxt  = C_A0;
      state_nxt = S_AESW;
    end

    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nh_r    <= '0;
      nt_r    <= '0;
      nlen_r  <= 4'd13;
      k256_r  <= 1'b0;
      state_r <= S_FETCH;
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && phase_r == PH_IDLE) begin
        unique case (cfg_index)
          REG_KEY0:  key_r[255:192] <= cfg_data;
          REG_KEY1:  key_r[191:128] <= cfg_data;
          REG_KEY2:  key_r[127:64]  <= cfg_data;
          REG_KEY3:  key_r[63:0]    <= cfg_data;
          REG_NHEAD: nh_r   <= cfg_data;
          REG_NTAIL: nt_r   <= cfg_data[39:0];
          REG_NLEN:  nlen_r <= cfg_data[3:0];
          REG_K256:  k256_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cont_r  <= cont_nxt;
    stat_r  <= stat_nxt;
    slast_r <= slast_nxt;
    dir_r   <= dir_nxt;
    mism_r  <= mism_nxt;
    ctr_r   <= ctr_nxt;
    blen_r  <= blen_nxt;
    alen_r  <= alen_nxt;
    mac_r   <= mac_nxt;
    ks_r    <= ks_nxt;
    gath_r  <= gath_nxt;
    d_r     <= d_nxt;
    if (emit) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    aes_req.start |-> !aes_rsp.busy)
    else $error("AES started while a pass is running");
  a_pay_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_PAY) |-> out_r.status == ST_OK)
    else $error("payload result carries a status");
  a_tag_seal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TAGOUT |-> !dir_r)
    else $error("tag emitted while opening");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 5'd16)
    else $error("byte position out of range");

endmodule
